@@ rtl/rta_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table allocator package
// Shared widths, codes, table entry type and cell control bundle.
// ----------------------------------------------------------------------------
package rta_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned PAGE_W = 21;
  localparam int unsigned SIZE_W = 32;

  localparam int unsigned MAX_REGIONS_DEF = 512;
  localparam int unsigned PAGE_BYTES_DEF  = 4096;

  localparam logic [PAGE_W-1:0] PAGES_MAX = '1;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_CHECK   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [PAGE_W-1:0] pages;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/rta_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table cell
// Holds one table entry; loads the table image or takes its neighbour's entry.
// ----------------------------------------------------------------------------
module rta_cell (
  input  logic               clk_i,
  input  rta_pkg::cell_ctrl_t ctrl_i,
  input  rta_pkg::entry_t    load_i,
  input  rta_pkg::entry_t    nb_i,
  output rta_pkg::entry_t    q_o
);

  rta_pkg::entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      entry_q <= load_i;
    end else if (ctrl_i.shift) begin
      entry_q <= nb_i;
    end
  end

  assign q_o = entry_q;

endmodule

@@ rtl/rta_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table sequencer
// Rotates the cell ring once per scanned item; works on the entry at its head.
// ----------------------------------------------------------------------------
module rta_ctrl #(
  parameter int unsigned MAX_REGIONS = rta_pkg::MAX_REGIONS_DEF,
  parameter int unsigned PAGE_BYTES  = rta_pkg::PAGE_BYTES_DEF,
  localparam int unsigned CW = $clog2(MAX_REGIONS + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rta_pkg::ADDR_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [rta_pkg::SIZE_W-1:0]  size_bytes_i,
  input  logic [rta_pkg::ADDR_W-1:0]  address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [rta_pkg::ADDR_W-1:0]  region_start_o,
  output logic [rta_pkg::PAGE_W-1:0]  page_count_o,
  output logic                        legitimate_o,
  input  rta_pkg::entry_t             head_i,
  input  rta_pkg::entry_t             nxt_i,
  output rta_pkg::entry_t             tail_o,
  output rta_pkg::entry_t             load_o,
  output rta_pkg::cell_ctrl_t         cell_ctrl_o,
  output logic [CW-1:0]               count_o
);

  localparam int unsigned LW = $clog2(MAX_REGIONS);
  localparam int unsigned S  = $clog2(PAGE_BYTES);
  localparam int unsigned EW = rta_pkg::ADDR_W + 1 + S;
  localparam logic [LW-1:0] LAST_STEP = LW'(MAX_REGIONS - 1);
  localparam int unsigned SIZE_W_P1 = rta_pkg::SIZE_W + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                      state_q, state_d;
  logic [LW-1:0]               t_q;
  logic [CW-1:0]               count_q;
  logic                        found_q;
  logic                        init_q;
  logic                        out_valid_q;
  logic [rta_pkg::ADDR_W-1:0]  base_q;

  logic [1:0]                  op_q;
  logic [rta_pkg::ADDR_W-1:0]  addr_q;
  logic [rta_pkg::PAGE_W-1:0]  preq_q;
  logic [rta_pkg::ADDR_W-1:0]  cap_end_q;

  logic [1:0]                  res_status_q;
  logic [rta_pkg::ADDR_W-1:0]  res_start_q;
  logic [rta_pkg::PAGE_W-1:0]  res_pages_q;
  logic                        res_legit_q;

  logic [1:0]                  out_status_q;
  logic [rta_pkg::ADDR_W-1:0]  out_start_q;
  logic [rta_pkg::PAGE_W-1:0]  out_pages_q;
  logic                        out_legit_q;

  logic                        accept;
  logic                        full;
  logic [SIZE_W_P1-1:0]        sz_round;
  logic [SIZE_W_P1-1:0]        pg_raw;
  logic [rta_pkg::PAGE_W-1:0]  preq;
  logic                        live;
  logic                        at_count;
  logic                        at_last_live;
  logic                        last_step;
  logic                        is_alloc, is_release, is_check;
  logic                        match;
  logic [EW-1:0]               span;
  logic [EW-1:0]               lo, hi, addr_x;
  logic                        hit;
  logic [rta_pkg::ADDR_W-1:0]  end32;
  logic [rta_pkg::ADDR_W-1:0]  new_start;
  logic                        out_free;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = init_q || (state_q != ST_IDLE);
  assign full       = count_q >= CW'(MAX_REGIONS);

  assign sz_round = {1'b0, size_bytes_i} + SIZE_W_P1'(PAGE_BYTES - 1);
  assign pg_raw   = sz_round >> S;
  assign preq     = (pg_raw > SIZE_W_P1'(rta_pkg::PAGES_MAX)) ? rta_pkg::PAGES_MAX
                                                              : pg_raw[rta_pkg::PAGE_W-1:0];

  assign is_alloc   = (op_q == rta_pkg::OP_ALLOC);
  assign is_release = (op_q == rta_pkg::OP_RELEASE);
  assign is_check   = (op_q == rta_pkg::OP_CHECK);

  assign live         = CW'(t_q) < count_q;
  assign at_count     = CW'(t_q) == count_q;
  assign at_last_live = (count_q != '0) && (CW'(t_q) == (count_q - CW'(1)));
  assign last_step    = (t_q == LAST_STEP);

  assign match = is_release && live && !found_q && (head_i.start == addr_q);

  assign span   = EW'(head_i.pages) << S;
  assign lo     = EW'(head_i.start);
  assign hi     = lo + span;
  assign addr_x = EW'(addr_q);
  assign hit    = is_check && live && (addr_x >= lo) && (addr_x < hi);

  assign end32     = head_i.start + span[rta_pkg::ADDR_W-1:0];
  assign new_start = (count_q == '0) ? base_q : cap_end_q;

  always_comb begin
    tail_o = head_i;
    if (is_release && (found_q || match)) begin
      tail_o = last_step ? '0 : nxt_i;
    end else if (is_alloc && at_count) begin
      tail_o.start = new_start;
      tail_o.pages = preq_q;
    end
  end

  assign load_o.start      = base_q;
  assign load_o.pages      = rta_pkg::PAGE_W'(1);
  assign cell_ctrl_o.load  = init_q;
  assign cell_ctrl_o.shift = (state_q == ST_SCAN);

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if ((opcode_i == rta_pkg::OP_ALLOC && full) ||
              !(opcode_i inside {rta_pkg::OP_ALLOC, rta_pkg::OP_RELEASE,
                                 rta_pkg::OP_CHECK})) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (last_step) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      t_q         <= '0;
      count_q     <= CW'(1);
      found_q     <= 1'b0;
      init_q      <= 1'b1;
      out_valid_q <= 1'b0;
      base_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        base_q <= cfg_wdata_i;
        init_q <= 1'b1;
      end else if (init_q) begin
        init_q  <= 1'b0;
        count_q <= CW'(1);
      end
      if (accept) begin
        t_q     <= '0;
        found_q <= 1'b0;
      end
      if (state_q == ST_SCAN) begin
        t_q <= t_q + LW'(1);
        if (match) found_q <= 1'b1;
        if (last_step) begin
          if (is_alloc) begin
            count_q <= count_q + CW'(1);
          end else if (is_release && (found_q || match)) begin
            count_q <= count_q - CW'(1);
          end
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= opcode_i;
      addr_q <= address_i;
      preq_q <= preq;
      case (opcode_i)
        rta_pkg::OP_ALLOC: begin
          res_status_q <= full ? rta_pkg::STATUS_FULL : rta_pkg::STATUS_OK;
          res_start_q  <= '0;
          res_pages_q  <= '0;
          res_legit_q  <= 1'b0;
        end
        rta_pkg::OP_RELEASE: begin
          res_status_q <= rta_pkg::STATUS_NOT_FOUND;
          res_start_q  <= address_i;
          res_pages_q  <= '0;
          res_legit_q  <= 1'b0;
        end
        rta_pkg::OP_CHECK: begin
          res_status_q <= rta_pkg::STATUS_OK;
          res_start_q  <= '0;
          res_pages_q  <= '0;
          res_legit_q  <= (address_i == base_q);
        end
        default: begin
          res_status_q <= rta_pkg::STATUS_OK;
          res_start_q  <= '0;
          res_pages_q  <= '0;
          res_legit_q  <= 1'b0;
        end
      endcase
    end
    if (state_q == ST_SCAN) begin
      if (is_alloc && at_last_live) cap_end_q <= end32;
      if (is_alloc && at_count) begin
        res_start_q <= new_start;
        res_pages_q <= preq_q;
      end
      if (match) begin
        res_status_q <= rta_pkg::STATUS_OK;
        res_start_q  <= head_i.start;
        res_pages_q  <= head_i.pages;
      end
      if (hit) res_legit_q <= 1'b1;
    end
    if (state_q == ST_DONE && out_free) begin
      out_status_q <= res_status_q;
      out_start_q  <= res_start_q;
      out_pages_q  <= res_pages_q;
      out_legit_q  <= res_legit_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign region_start_o = out_start_q;
  assign page_count_o   = out_pages_q;
  assign legitimate_o   = out_legit_q;
  assign count_o        = count_q;

endmodule

@@ rtl/region_table_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table allocator core
// Table of allocated virtual regions: allocate, release and address check.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats (opcode, size, address) are taken on in_valid_i while
//   in_stall_o is low; one result beat leaves on out_valid_o and is taken
//   while out_stall_i is low. The result register holds a beat while the
//   receiver stalls; the next input beat is taken meanwhile.
//   The table lives in a ring of MAX_REGIONS cells. Allocate, release and
//   check rotate the whole ring once, one cell per cycle, and work on the
//   entry at its head, then pass their result to the result register.
//   An undefined opcode or an allocate on a full table skips the rotation
//   and goes straight to the result register. One beat is in work at a
//   time; a finished beat waits while an earlier result is stalled.
//   A write on cfg_we_i sets the base address and reloads the table in the
//   following cycle: base with one page, all other entries empty.
//   After reset the table is loaded the same way in the first cycle, with
//   base 0, and in_stall_o is high during that cycle.
// ----------------------------------------------------------------------------
module region_table_allocator_core #(
  parameter int unsigned MAX_REGIONS = rta_pkg::MAX_REGIONS_DEF,
  parameter int unsigned PAGE_BYTES  = rta_pkg::PAGE_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rta_pkg::ADDR_W-1:0]  cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  opcode_i,
  input  logic [rta_pkg::SIZE_W-1:0]  size_bytes_i,
  input  logic [rta_pkg::ADDR_W-1:0]  address_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [rta_pkg::ADDR_W-1:0]  region_start_o,
  output logic [rta_pkg::PAGE_W-1:0]  page_count_o,
  output logic                        legitimate_o
);

  localparam int unsigned CW = $clog2(MAX_REGIONS + 1);

  rta_pkg::entry_t     cell_q [MAX_REGIONS];
  rta_pkg::entry_t     tail;
  rta_pkg::entry_t     load_val;
  rta_pkg::cell_ctrl_t cell_ctrl;
  logic [CW-1:0]       count;

  rta_ctrl #(
    .MAX_REGIONS (MAX_REGIONS),
    .PAGE_BYTES  (PAGE_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .size_bytes_i   (size_bytes_i),
    .address_i      (address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .region_start_o (region_start_o),
    .page_count_o   (page_count_o),
    .legitimate_o   (legitimate_o),
    .head_i         (cell_q[0]),
    .nxt_i          (cell_q[1]),
    .tail_o         (tail),
    .load_o         (load_val),
    .cell_ctrl_o    (cell_ctrl),
    .count_o        (count)
  );

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    rta_pkg::entry_t nb;
    rta_pkg::entry_t ld;
    if (i == MAX_REGIONS - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    if (i == 0) begin : g_head
      assign ld = load_val;
    end else begin : g_rest
      assign ld = '0;
    end
    rta_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .load_i (ld),
      .nb_i   (nb),
      .q_o    (cell_q[i])
    );
  end

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(MAX_REGIONS))
    else $error("region count above table size");

  a_one_in_work : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second beat taken while one is in work");

  a_full_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == rta_pkg::STATUS_FULL) |->
      (region_start_o == '0 && page_count_o == '0 && !legitimate_o))
    else $error("table full result carries a region");

  a_legit_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && legitimate_o) |-> (status_o == rta_pkg::STATUS_OK))
    else $error("legitimate flag with error status");

endmodule

@@ dv/region_table_allocator_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Region table allocator core testbench
// Sends allocate, release, check and undefined beats with random idling on
// both channels. Keeps its own copy of the region table to predict each
// result and compares every result beat in order, field by field. Covers
// several base addresses, a full table and an emptied table.
// ----------------------------------------------------------------------------
module region_table_allocator_core_tb;

  localparam int unsigned MAX_REGIONS = rta_pkg::MAX_REGIONS_DEF;
  localparam int unsigned PAGE_BYTES  = rta_pkg::PAGE_BYTES_DEF;
  localparam int unsigned ADDR_W      = rta_pkg::ADDR_W;
  localparam int unsigned PAGE_W      = rta_pkg::PAGE_W;
  localparam int unsigned SIZE_W      = rta_pkg::SIZE_W;
  localparam logic [1:0]  OP_UNDEFINED = 2'd3;
  localparam int unsigned IDLE_PCT    = 26;
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    rta_pkg::status_e  status;
    logic [ADDR_W-1:0] start;
    logic [PAGE_W-1:0] pages;
    logic              legit;
  } outcome_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              cfg_we_i     = 1'b0;
  logic [ADDR_W-1:0] cfg_wdata_i  = '0;
  logic              in_valid_i   = 1'b0;
  logic              in_stall_o;
  logic [1:0]        opcode_i     = '0;
  logic [SIZE_W-1:0] size_bytes_i = '0;
  logic [ADDR_W-1:0] address_i    = '0;
  logic              out_valid_o;
  logic              out_stall_i  = 1'b0;
  logic [1:0]        status_o;
  logic [ADDR_W-1:0] region_start_o;
  logic [PAGE_W-1:0] page_count_o;
  logic              legitimate_o;

  logic [ADDR_W-1:0] pool_base;
  logic [ADDR_W-1:0] live_start [MAX_REGIONS];
  logic [PAGE_W-1:0] live_pages [MAX_REGIONS];
  int unsigned       live_count;
  outcome_t          outcome_q [$];
  int unsigned       fails = 0;
  int unsigned       cycle_count;
  bit                quiet = 1'b0;

  region_table_allocator_core #(
    .MAX_REGIONS(MAX_REGIONS),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .opcode_i      (opcode_i),
    .size_bytes_i  (size_bytes_i),
    .address_i     (address_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .region_start_o(region_start_o),
    .page_count_o  (page_count_o),
    .legitimate_o  (legitimate_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void reload_table(logic [ADDR_W-1:0] base);
    pool_base = base;
    for (int i = 0; i < MAX_REGIONS; i++) begin
      live_start[i] = '0;
      live_pages[i] = '0;
    end
    live_start[0] = base;
    live_pages[0] = PAGE_W'(1);
    live_count    = 1;
  endfunction

  function automatic outcome_t compute_outcome(logic [1:0] op, logic [SIZE_W-1:0] size,
                                               logic [ADDR_W-1:0] addr);
    outcome_t    res;
    logic [63:0] pages;
    logic [63:0] lo;
    logic [63:0] hi;
    int          idx;
    res.status = rta_pkg::STATUS_OK;
    res.start  = '0;
    res.pages  = '0;
    res.legit  = 1'b0;
    case (op)
      rta_pkg::OP_ALLOC: begin
        if (live_count >= MAX_REGIONS) begin
          res.status = rta_pkg::STATUS_FULL;
        end else begin
          pages = (64'(size) + PAGE_BYTES - 1) / PAGE_BYTES;
          if (pages > 64'(rta_pkg::PAGES_MAX)) pages = 64'(rta_pkg::PAGES_MAX);
          if (live_count == 0) begin
            res.start = pool_base;
          end else begin
            hi = 64'(live_start[live_count-1]) + 64'(live_pages[live_count-1]) * PAGE_BYTES;
            res.start = hi[ADDR_W-1:0];
          end
          res.pages = pages[PAGE_W-1:0];
          live_start[live_count] = res.start;
          live_pages[live_count] = res.pages;
          live_count++;
        end
      end
      rta_pkg::OP_RELEASE: begin
        idx = -1;
        for (int i = 0; idx < 0 && i < live_count; i++) begin
          if (live_start[i] == addr) idx = i;
        end
        if (idx < 0) begin
          res.status = rta_pkg::STATUS_NOT_FOUND;
          res.start  = addr;
        end else begin
          res.start = live_start[idx];
          res.pages = live_pages[idx];
          for (int i = idx; i + 1 < live_count; i++) begin
            live_start[i] = live_start[i+1];
            live_pages[i] = live_pages[i+1];
          end
          live_start[live_count-1] = '0;
          live_pages[live_count-1] = '0;
          live_count--;
        end
      end
      rta_pkg::OP_CHECK: begin
        res.legit = (addr == pool_base);
        for (int i = 0; !res.legit && i < live_count; i++) begin
          lo = 64'(live_start[i]);
          hi = lo + 64'(live_pages[i]) * PAGE_BYTES;
          if (64'(addr) >= lo && 64'(addr) < hi) res.legit = 1'b1;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(logic [1:0] op, logic [SIZE_W-1:0] size,
                              logic [ADDR_W-1:0] addr);
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    size_bytes_i <= size;
    address_i    <= addr;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    outcome_q.push_back(compute_outcome(op, size, addr));
    if (!quiet) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
  endtask

  task automatic write_base(logic [ADDR_W-1:0] value);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    reload_table(value);
  endtask

  task automatic send_random_request();
    int unsigned       pick;
    int unsigned       slot;
    logic [63:0]       span;
    logic [63:0]       offs;
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
    pick = $urandom_range(99);
    size = $urandom();
    addr = $urandom();
    slot = (live_count > 0) ? $urandom_range(live_count - 1) : 0;
    span = 64'(live_pages[slot]) * PAGE_BYTES;
    offs = (span == 0) ? 64'd0 : 64'($urandom()) % span;
    if (pick < 25) begin
      case ($urandom_range(3))
        0: size = $urandom_range(4 * PAGE_BYTES);
        1: size = PAGE_BYTES * $urandom_range(1, 8) + $urandom_range(2) - 1;
        2: size = '0;
        default: ;
      endcase
      send_request(rta_pkg::OP_ALLOC, size, addr);
    end else if (pick < 55) begin
      if (live_count > 0 && $urandom_range(4) != 0) addr = live_start[slot];
      send_request(rta_pkg::OP_RELEASE, size, addr);
    end else if (pick < 95) begin
      case ($urandom_range(4))
        0: addr = pool_base;
        1: addr = live_start[slot] + offs[ADDR_W-1:0];
        2: addr = live_start[slot] + span[ADDR_W-1:0];
        3: addr = live_start[slot] - 1;
        default: ;
      endcase
      send_request(rta_pkg::OP_CHECK, size, addr);
    end else begin
      send_request(OP_UNDEFINED, size, addr);
    end
  endtask

  task automatic test_basic_ops();
    send_request(rta_pkg::OP_CHECK, '0, '0);
    send_request(rta_pkg::OP_CHECK, '1, PAGE_BYTES);
    send_request(rta_pkg::OP_CHECK, '0, PAGE_BYTES - 1);
    send_request(rta_pkg::OP_ALLOC, '0, '0);
    send_request(rta_pkg::OP_CHECK, '0, PAGE_BYTES);
    send_request(rta_pkg::OP_ALLOC, 1, '1);
    send_request(rta_pkg::OP_ALLOC, PAGE_BYTES, '0);
    send_request(rta_pkg::OP_ALLOC, PAGE_BYTES + 1, '0);
    send_request(rta_pkg::OP_ALLOC, '1, '0);
    send_request(rta_pkg::OP_CHECK, '0, '1);
    send_request(rta_pkg::OP_RELEASE, '0, 32'h0000_1234);
    send_request(rta_pkg::OP_RELEASE, '1, PAGE_BYTES);
    send_request(rta_pkg::OP_RELEASE, '0, PAGE_BYTES);
    send_request(rta_pkg::OP_RELEASE, '0, '0);
    send_request(rta_pkg::OP_CHECK, '0, '0);
    send_request(OP_UNDEFINED, '1, '1);
    send_request(OP_UNDEFINED, '0, '0);
  endtask

  task automatic test_wrap_and_empty();
    write_base('1);
    send_request(rta_pkg::OP_ALLOC, 1, '0);
    send_request(rta_pkg::OP_CHECK, '0, 32'h0000_0FFF);
    send_request(rta_pkg::OP_CHECK, '0, 32'h0000_1FFF);
    send_request(rta_pkg::OP_RELEASE, '0, '1);
    send_request(rta_pkg::OP_RELEASE, '0, 32'h0000_0FFF);
    send_request(rta_pkg::OP_CHECK, '0, '1);
    send_request(rta_pkg::OP_ALLOC, 2 * PAGE_BYTES, '0);
    send_request(rta_pkg::OP_CHECK, '0, '0);
  endtask

  task automatic test_table_full();
    int unsigned slot;
    write_base($urandom());
    while (live_count < MAX_REGIONS) begin
      quiet = (live_count < MAX_REGIONS / 2);
      send_request(rta_pkg::OP_ALLOC, $urandom_range(3 * PAGE_BYTES), $urandom());
    end
    quiet = 1'b0;
    repeat (3) send_request(rta_pkg::OP_ALLOC, $urandom(), $urandom());
    repeat (6) begin
      slot = $urandom_range(live_count - 1);
      send_request(rta_pkg::OP_RELEASE, $urandom(), live_start[slot]);
      send_request(rta_pkg::OP_CHECK, $urandom(), live_start[slot] + PAGE_BYTES / 2);
    end
    while (live_count < MAX_REGIONS) begin
      send_request(rta_pkg::OP_ALLOC, $urandom(), $urandom());
    end
    send_request(rta_pkg::OP_ALLOC, '0, '0);
  endtask

  task automatic test_random_mix();
    logic [ADDR_W-1:0] bases [4];
    bases[0] = '0;
    bases[1] = 32'hFFFF_F000;
    bases[2] = $urandom();
    bases[3] = $urandom();
    foreach (bases[p]) begin
      write_base(bases[p]);
      repeat (160) send_random_request();
    end
  endtask

  always @(negedge clk_i) out_stall_i <= !quiet && ($urandom_range(99) < IDLE_PCT);

  always @(posedge clk_i) begin
    outcome_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $error("result beat with nothing outstanding");
        fails++;
      end else begin
        want = outcome_q.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          fails++;
        end
        if (region_start_o !== want.start) begin
          $error("region_start: expected %h, got %h", want.start, region_start_o);
          fails++;
        end
        if (page_count_o !== want.pages) begin
          $error("page_count: expected %0d, got %0d", want.pages, page_count_o);
          fails++;
        end
        if (legitimate_o !== want.legit) begin
          $error("legitimate: expected %0d, got %0d", want.legit, legitimate_o);
          fails++;
        end
      end
    end
  end

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    reload_table('0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_ops();
    test_wrap_and_empty();
    test_table_full();
    test_random_mix();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (MAX_REGIONS + 16) @(posedge clk_i);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rta_pkg.sv
rtl/rta_cell.sv
rtl/rta_ctrl.sv
rtl/region_table_allocator_core.sv
dv/region_table_allocator_core_tb.sv
